@@ hw/rtl/ictf_pkg.sv @@
// ----------------------------------------------------------------------------
// ictf_pkg
// Shared widths, constants, the queue entry type and the arctangent table of
// the complementary tilt filter.
// ----------------------------------------------------------------------------
package ictf_pkg;

  localparam int SMP_W      = 16;
  localparam int ANG_W      = 27;
  localparam int ALPHA_W    = 17;
  localparam int LSB_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;
  localparam int SQ_W       = 32;
  localparam int MAG_W      = 32;
  localparam int CORD_W     = 28;
  localparam int ZW         = 32;
  localparam int ROOT_W     = 24;
  localparam int NUM_W      = 48;
  localparam int DEN_W      = 36;
  localparam int QUO_W      = 28;
  localparam int QUEUE_DEPTH = 2;

  localparam int CORDIC_ITERATIONS_DEF = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LSB    = 8'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd62915;
  localparam logic [LSB_W-1:0]   LSB_RESET   = 16'd131;
  localparam logic [19:0]        US_PER_S    = 20'd1000000;
  localparam logic signed [ZW-1:0] DEG90_Q16 = 32'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 27'sd67108863;
  localparam logic signed [ANG_W-1:0] ANG_MIN = -27'sd67108864;

  typedef struct packed {
    logic signed [SMP_W-1:0] ax;
    logic signed [SMP_W-1:0] ay;
    logic signed [SMP_W-1:0] az;
    logic [SQ_W-1:0]         sq;
    logic [MAG_W-1:0]        mag_p;
    logic                    neg_p;
    logic [MAG_W-1:0]        mag_r;
    logic                    neg_r;
  } item_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/ictf_front.sv @@
// ----------------------------------------------------------------------------
// ictf_front
// Takes raw samples, forms the squared y-z accelerometer norm and the gyro
// magnitudes with their signs, and pushes them into the queue.
// ----------------------------------------------------------------------------
module ictf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ictf_pkg::SMP_W-1:0] accel_x_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] accel_y_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] accel_z_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] rate_x_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] rate_y_i,
  input  logic [ictf_pkg::SMP_W-1:0]        interval_us_i,
  input  logic                              full_i,
  output logic                              push_o,
  output ictf_pkg::item_t                   item_o
);

  logic                              valid_q;
  logic signed [ictf_pkg::SMP_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic [ictf_pkg::SMP_W-1:0]        dt_q;
  logic                              accept;

  logic signed [31:0] ay2, az2;
  logic signed [16:0] gx_ext, gy_ext;
  logic [16:0]        gx_abs, gy_abs;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= rate_x_i;
      gy_q <= rate_y_i;
      dt_q <= interval_us_i;
    end
  end

  assign ay2    = ay_q * ay_q;
  assign az2    = az_q * az_q;
  assign gx_ext = 17'(gx_q);
  assign gy_ext = 17'(gy_q);
  assign gx_abs = gx_ext[16] ? 17'(-gx_ext) : gx_ext;
  assign gy_abs = gy_ext[16] ? 17'(-gy_ext) : gy_ext;

  always_comb begin
    item_o.ax    = ax_q;
    item_o.ay    = ay_q;
    item_o.az    = az_q;
    item_o.sq    = 32'(ay2) + 32'(az2);
    item_o.mag_p = ictf_pkg::MAG_W'(gx_abs * dt_q);
    item_o.neg_p = gx_q[15];
    item_o.mag_r = ictf_pkg::MAG_W'(gy_abs * dt_q);
    item_o.neg_r = gy_q[15];
  end

endmodule

@@ hw/rtl/ictf_queue.sv @@
// ----------------------------------------------------------------------------
// ictf_queue
// Short FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module ictf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ictf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ictf_pkg::item_t item_o
);

  localparam int PW = (ictf_pkg::QUEUE_DEPTH > 1) ? $clog2(ictf_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(ictf_pkg::QUEUE_DEPTH + 1);

  ictf_pkg::item_t entry_q [ictf_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(ictf_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(ictf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(ictf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/ictf_div.sv @@
// ----------------------------------------------------------------------------
// ictf_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module ictf_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ictf_pkg::NUM_W-1:0]      num_i,
  input  logic [ictf_pkg::DEN_W-1:0]      den_i,
  output logic                            busy_o,
  output logic [ictf_pkg::QUO_W-1:0]      quo_o
);

  localparam int CW = $clog2(ictf_pkg::QUO_W);

  logic [ictf_pkg::DEN_W-1:0] rem_q;
  logic [ictf_pkg::QUO_W-1:0] quo_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q;
  logic [ictf_pkg::DEN_W:0]   trial;
  logic                       ge;

  assign trial  = {rem_q, quo_q[ictf_pkg::QUO_W-1]};
  assign ge     = (trial >= {1'b0, den_i});
  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(ictf_pkg::QUO_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= ictf_pkg::DEN_W'(num_i[ictf_pkg::NUM_W-1:ictf_pkg::QUO_W]);
      quo_q <= num_i[ictf_pkg::QUO_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? ictf_pkg::DEN_W'(trial - {1'b0, den_i}) : ictf_pkg::DEN_W'(trial);
      quo_q <= {quo_q[ictf_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/ictf_cordic.sv @@
// ----------------------------------------------------------------------------
// ictf_cordic
// Iterative vectoring CORDIC giving atan2(y, x) in 1/65536 degree, one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ictf_cordic #(
  parameter int ITER = ictf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ictf_pkg::CORD_W-1:0] x_i,
  input  logic signed [ictf_pkg::CORD_W-1:0] y_i,
  output logic                               busy_o,
  output logic signed [ictf_pkg::ZW-1:0]     z_o
);

  localparam int CW = $clog2(ITER + 1);

  logic signed [ictf_pkg::CORD_W-1:0] x_q, y_q, dx, dy;
  logic signed [ictf_pkg::ZW-1:0]     z_q, step;
  logic [CW-1:0]                      cnt_q;
  logic                               busy_q, zero_q;

  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign step   = ictf_pkg::atan_q16(5'(cnt_q));
  assign busy_o = busy_q;
  assign z_o    = zero_q ? '0 : z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(ITER - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // rotate the left half-plane onto the right one first
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= y_i;
          y_q <= -x_i;
          z_q <= ictf_pkg::DEG90_Q16;
        end else begin
          x_q <= -y_i;
          y_q <= x_i;
          z_q <= -ictf_pkg::DEG90_Q16;
        end
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[ictf_pkg::CORD_W-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + step;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - step;
      end
    end
  end

endmodule

@@ hw/rtl/ictf_back.sv @@
// ----------------------------------------------------------------------------
// ictf_back
// Back end: square root of the norm, gyro increments and the two CORDIC
// passes, then the blend with the stored estimates and the result register.
// ----------------------------------------------------------------------------
module ictf_back #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ictf_pkg::ALPHA_W-1:0]       alpha_i,
  input  logic [ictf_pkg::LSB_W-1:0]         lsb_i,
  input  logic                               q_valid_i,
  input  ictf_pkg::item_t                    item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ictf_pkg::ANG_W-1:0]  pitch_angle_o,
  output logic signed [ictf_pkg::ANG_W-1:0]  roll_angle_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_ROLL, ST_BLEND, ST_OUT} state_e;

  state_e          state_q;
  ictf_pkg::item_t item_q;
  logic [ictf_pkg::DEN_W-1:0] den_q;

  // ---- square root ---------------------------------------------------------
  logic [ictf_pkg::NUM_W-1:0]  sq_n_q;
  logic [27:0]                 sq_rem_q, sq_t, sq_trial;
  logic [ictf_pkg::ROOT_W-1:0] sq_root_q;
  logic [4:0]                  sq_cnt_q;
  logic                        sq_busy_q, sq_ge;

  logic start_run, start_roll, all_idle;
  logic div_p_busy, div_r_busy, cor_busy;
  logic [ictf_pkg::QUO_W-1:0] quo_p, quo_r;
  logic signed [ictf_pkg::ZW-1:0] cor_z;
  logic signed [ictf_pkg::ZW-1:0] acc_p_q;
  logic signed [ictf_pkg::CORD_W-1:0] cor_x, cor_y, ay_s, az_s, ax_s;
  logic [ictf_pkg::NUM_W-1:0] num_p, num_r;

  assign start_run  = (state_q == ST_IDLE) && q_valid_i;
  assign pop_o      = start_run;
  assign all_idle   = !div_p_busy && !div_r_busy && !cor_busy && !sq_busy_q;
  assign start_roll = (state_q == ST_RUN) && all_idle;

  always_ff @(posedge clk_i) begin
    den_q <= ictf_pkg::DEN_W'(lsb_i * ictf_pkg::US_PER_S);
  end

  assign sq_t     = {sq_rem_q[25:0], sq_n_q[ictf_pkg::NUM_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (start_run) begin
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= '0;
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q + 1'b1;
      if (sq_cnt_q == 5'(ictf_pkg::ROOT_W - 1)) begin
        sq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_run) begin
      sq_n_q    <= {item_i.sq, 16'b0};
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_busy_q) begin
      sq_n_q    <= {sq_n_q[ictf_pkg::NUM_W-3:0], 2'b00};
      sq_rem_q  <= sq_ge ? sq_t - sq_trial : sq_t;
      sq_root_q <= {sq_root_q[ictf_pkg::ROOT_W-2:0], sq_ge};
    end
  end

  // ---- gyro increments -----------------------------------------------------
  assign num_p = {item_i.mag_p, 16'b0} + ictf_pkg::NUM_W'(den_q >> 1);
  assign num_r = {item_i.mag_r, 16'b0} + ictf_pkg::NUM_W'(den_q >> 1);

  ictf_div u_div_p (
    .clk_i, .rst_ni, .start_i(start_run), .num_i(num_p), .den_i(den_q),
    .busy_o(div_p_busy), .quo_o(quo_p)
  );

  ictf_div u_div_r (
    .clk_i, .rst_ni, .start_i(start_run), .num_i(num_r), .den_i(den_q),
    .busy_o(div_r_busy), .quo_o(quo_r)
  );

  // ---- atan2, pitch first, then roll --------------------------------------
  assign ay_s  = {{(ictf_pkg::CORD_W-24){item_i.ay[15]}}, item_i.ay, 8'b0};
  assign az_s  = {{(ictf_pkg::CORD_W-24){item_i.az[15]}}, item_i.az, 8'b0};
  assign ax_s  = {{(ictf_pkg::CORD_W-24){item_q.ax[15]}}, item_q.ax, 8'b0};
  assign cor_x = start_run ? az_s : ictf_pkg::CORD_W'(sq_root_q);
  assign cor_y = start_run ? ay_s : -ax_s;

  ictf_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni, .start_i(start_run || start_roll), .x_i(cor_x), .y_i(cor_y),
    .busy_o(cor_busy), .z_o(cor_z)
  );

  // ---- blend ---------------------------------------------------------------
  logic signed [ictf_pkg::ANG_W-1:0] est_p_q, est_r_q;
  logic signed [28:0]  incr_p, incr_r;
  logic signed [32:0]  sum_p, sum_r, op_v;
  logic signed [17:0]  op_w;
  logic [ictf_pkg::ALPHA_W-1:0] beta;
  logic signed [50:0]  mul_q, acc_sum_q;
  logic signed [51:0]  blend_v;
  logic signed [35:0]  blend_sh;
  logic signed [ictf_pkg::ANG_W-1:0] blend_sat;
  logic [2:0]          bl_q;

  assign incr_p = item_q.neg_p ? -29'(quo_p) : 29'(quo_p);
  assign incr_r = item_q.neg_r ? -29'(quo_r) : 29'(quo_r);
  assign sum_p  = 33'(est_p_q) + 33'(incr_p);
  assign sum_r  = 33'(est_r_q) + 33'(incr_r);
  assign beta   = ictf_pkg::ALPHA_ONE - alpha_i;

  always_comb begin
    case (bl_q)
      3'd0:    begin op_w = {1'b0, alpha_i}; op_v = sum_p; end
      3'd1:    begin op_w = {1'b0, beta};    op_v = 33'(acc_p_q); end
      3'd2:    begin op_w = {1'b0, alpha_i}; op_v = sum_r; end
      default: begin op_w = {1'b0, beta};    op_v = 33'(cor_z); end
    endcase
  end

  // round half up, then clamp to +/-1024 degrees
  assign blend_v  = 52'(acc_sum_q) + 52'(mul_q) + 52'sd32768;
  assign blend_sh = 36'(blend_v >>> 16);
  always_comb begin
    if (blend_sh > 36'(ictf_pkg::ANG_MAX)) begin
      blend_sat = ictf_pkg::ANG_MAX;
    end else if (blend_sh < 36'(ictf_pkg::ANG_MIN)) begin
      blend_sat = ictf_pkg::ANG_MIN;
    end else begin
      blend_sat = ictf_pkg::ANG_W'(blend_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_o   <= 1'b0;
      est_p_q       <= '0;
      est_r_q       <= '0;
      bl_q          <= '0;
      pitch_angle_o <= '0;
      roll_angle_o  <= '0;
    end else begin
      if (out_valid_o && !out_stall_i && state_q != ST_OUT) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (all_idle) begin
            state_q <= ST_ROLL;
          end
        end
        ST_ROLL: begin
          if (!cor_busy) begin
            bl_q    <= '0;
            state_q <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          bl_q <= bl_q + 1'b1;
          if (bl_q == 3'd2) begin
            est_p_q <= blend_sat;
          end
          if (bl_q == 3'd4) begin
            est_r_q <= blend_sat;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the result register is free
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o   <= 1'b1;
            pitch_angle_o <= est_p_q;
            roll_angle_o  <= est_r_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_run) begin
      item_q <= item_i;
    end
    if (start_roll) begin
      acc_p_q <= cor_z;
    end
    mul_q <= 51'(op_w * op_v);
    if (bl_q == 3'd1 || bl_q == 3'd3) begin
      acc_sum_q <= mul_q;
    end
  end

endmodule

@@ hw/rtl/imu_complementary_tilt_filter.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Pitch and roll complementary filter over raw accelerometer and gyro samples.
// ----------------------------------------------------------------------------
// Each sample yields one pitch/roll pair in 1/65536 degree, saturated at
// +/-1024 degrees. While a sample occupies the back end, the single CORDIC
// unit computes the pitch angle alongside the square root and the two gyro
// dividers, then the roll angle, followed by the blend on one shared
// multiplier. A two-entry queue lets the front take samples while the back
// is busy, and the result register lets the next sample start while a
// result waits to be taken.
// Configuration is written through a port that is always ready.
module imu_complementary_tilt_filter #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ictf_pkg::SMP_W-1:0]     accel_x_i,
  input  logic signed [ictf_pkg::SMP_W-1:0]     accel_y_i,
  input  logic signed [ictf_pkg::SMP_W-1:0]     accel_z_i,
  input  logic signed [ictf_pkg::SMP_W-1:0]     rate_x_i,
  input  logic signed [ictf_pkg::SMP_W-1:0]     rate_y_i,
  input  logic [ictf_pkg::SMP_W-1:0]            interval_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ictf_pkg::ANG_W-1:0]     pitch_angle_o,
  output logic signed [ictf_pkg::ANG_W-1:0]     roll_angle_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ictf_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [ictf_pkg::ALPHA_W-1:0] alpha_q, alpha_eff;
  logic [ictf_pkg::LSB_W-1:0]   lsb_q, lsb_eff;
  logic                         q_full, q_push, q_pop, q_valid;
  ictf_pkg::item_t              front_item, head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ictf_pkg::ALPHA_RESET;
      lsb_q   <= ictf_pkg::LSB_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ictf_pkg::CFG_BLEND_ALPHA) begin
        alpha_q <= cfg_data_i;
      end else if (cfg_index_i == ictf_pkg::CFG_GYRO_LSB) begin
        lsb_q <= cfg_data_i[ictf_pkg::LSB_W-1:0];
      end
    end
  end

  // clamp alpha to one and treat a zero scale as one
  assign alpha_eff = (alpha_q > ictf_pkg::ALPHA_ONE) ? ictf_pkg::ALPHA_ONE : alpha_q;
  assign lsb_eff   = (lsb_q == '0) ? ictf_pkg::LSB_W'(1) : lsb_q;

  ictf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .accel_x_i, .accel_y_i, .accel_z_i, .rate_x_i, .rate_y_i, .interval_us_i,
    .full_i(q_full), .push_o(q_push), .item_o(front_item)
  );

  ictf_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .item_i(front_item), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .item_o(head_item)
  );

  ictf_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk_i, .rst_ni, .alpha_i(alpha_eff), .lsb_i(lsb_eff),
    .q_valid_i(q_valid), .item_i(head_item), .pop_o(q_pop),
    .out_valid_o, .out_stall_i, .pitch_angle_o, .roll_angle_o
  );

endmodule

@@ dv/ictf_checker.sv @@
// ----------------------------------------------------------------------------
// ictf_checker
// Watches the sample, result and configuration channels of the tilt filter.
// It predicts each pitch/roll pair from its own model of the filter and
// compares every result taken with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ictf_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] accel_x_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] accel_y_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] accel_z_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] rate_x_i,
  input  logic signed [ictf_pkg::SMP_W-1:0] rate_y_i,
  input  logic [ictf_pkg::SMP_W-1:0]        interval_us_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [ictf_pkg::ANG_W-1:0] pitch_angle_i,
  input  logic signed [ictf_pkg::ANG_W-1:0] roll_angle_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ictf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic signed [ictf_pkg::ANG_W-1:0] pitch;
    logic signed [ictf_pkg::ANG_W-1:0] roll;
  } tilt_t;

  localparam longint ARC_TBL [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  tilt_t             tilt_q[$];
  logic [ictf_pkg::ALPHA_W-1:0] alpha_r;
  logic [ictf_pkg::LSB_W-1:0]   lsb_r;
  logic signed [ictf_pkg::ANG_W-1:0] pitch_est;
  logic signed [ictf_pkg::ANG_W-1:0] roll_est;

  function automatic longint root_floor(longint n);
    longint res;
    longint bitv;
    res  = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint tilt_atan2(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // fold the left half-plane onto the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 5898240;
      end else begin
        x = -y; y = t; z = -5898240;
      end
    end
    for (int i = 0; i < ictf_pkg::CORDIC_ITERATIONS_DEF; i++) begin
      dx = y >>> (i % 32);
      dy = x >>> (i % 32);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ARC_TBL[i % 32];
      end else begin
        x = x - dx; y = y + dy; z = z - ARC_TBL[i % 32];
      end
    end
    return z;
  endfunction

  function automatic longint rate_step(longint rate, longint dt, longint lsb);
    longint den;
    longint mag;
    longint q;
    if (lsb == 0) lsb = 1;
    den = lsb * 1000000;
    mag = (rate < 0 ? -rate : rate) * dt * 65536;
    q   = (mag + den / 2) / den;
    return rate < 0 ? -q : q;
  endfunction

  function automatic logic signed [ictf_pkg::ANG_W-1:0] fuse(longint est, longint incr,
                                                              longint acc, longint a);
    longint v;
    if (a > 65536) a = 65536;
    v = a * (est + incr) + (65536 - a) * acc + 32768;
    v = v >>> 16;
    if (v > 67108863) v = 67108863;
    if (v < -67108864) v = -67108864;
    return v[ictf_pkg::ANG_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    longint ax, ay, az, rad;
    tilt_t  want;
    int     errs;
    if (!rst_ni) begin
      alpha_r      <= ictf_pkg::ALPHA_RESET;
      lsb_r        <= ictf_pkg::LSB_RESET;
      pitch_est    <= '0;
      roll_est     <= '0;
      fail_count_o <= 0;
      tilt_q.delete();
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == ictf_pkg::CFG_BLEND_ALPHA)
          alpha_r <= cfg_data_i[ictf_pkg::ALPHA_W-1:0];
        else if (cfg_index_i == ictf_pkg::CFG_GYRO_LSB)
          lsb_r <= cfg_data_i[ictf_pkg::LSB_W-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        ax  = accel_x_i;
        ay  = accel_y_i;
        az  = accel_z_i;
        rad = root_floor((ay * ay + az * az) << 16);
        want.pitch = fuse(pitch_est, rate_step(rate_x_i, interval_us_i, lsb_r),
                          tilt_atan2(ay * 256, az * 256), alpha_r);
        want.roll  = fuse(roll_est, rate_step(rate_y_i, interval_us_i, lsb_r),
                          tilt_atan2(-ax * 256, rad), alpha_r);
        pitch_est <= want.pitch;
        roll_est  <= want.roll;
        tilt_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (tilt_q.size() == 0) begin
          $display("%0t: result with no request outstanding: pitch %0d roll %0d",
                   $time, pitch_angle_i, roll_angle_i);
          errs = errs + 1;
        end else begin
          want = tilt_q.pop_front();
          if (want.pitch !== pitch_angle_i) begin
            $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                     pitch_angle_i);
            errs = errs + 1;
          end
          if (want.roll !== roll_angle_i) begin
            $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                     roll_angle_i);
            errs = errs + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

  // requests outstanding, counting one accepted at this very edge
  assign pending_o = tilt_q.size();

endmodule

@@ dv/imu_complementary_tilt_filter_tb.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_tb
// Drives directed and random IMU samples through the tilt filter under random
// source gaps and sink stalls, across several blend and gyro-scale settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_tb;

  localparam int IDLE_LIMIT = 3000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  logic signed [ictf_pkg::SMP_W-1:0] accel_x     = '0;
  logic signed [ictf_pkg::SMP_W-1:0] accel_y     = '0;
  logic signed [ictf_pkg::SMP_W-1:0] accel_z     = '0;
  logic signed [ictf_pkg::SMP_W-1:0] rate_x      = '0;
  logic signed [ictf_pkg::SMP_W-1:0] rate_y      = '0;
  logic [ictf_pkg::SMP_W-1:0]        interval_us = '0;
  logic                              out_valid;
  logic                              out_stall   = 1'b0;
  logic signed [ictf_pkg::ANG_W-1:0] pitch_angle;
  logic signed [ictf_pkg::ANG_W-1:0] roll_angle;
  logic                              cfg_valid   = 1'b0;
  logic                              cfg_ready;
  logic [ictf_pkg::CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [ictf_pkg::CFG_DATA_W-1:0]   cfg_data    = '0;

  int fail_count;
  int pending;
  bit no_gaps   = 1'b0;
  bit no_stalls = 1'b0;
  int stall_left = 0;
  bit took_out;
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  imu_complementary_tilt_filter dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .accel_x_i(accel_x), .accel_y_i(accel_y), .accel_z_i(accel_z),
    .rate_x_i(rate_x), .rate_y_i(rate_y), .interval_us_i(interval_us),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pitch_angle_o(pitch_angle), .roll_angle_o(roll_angle),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ictf_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .accel_x_i(accel_x), .accel_y_i(accel_y), .accel_z_i(accel_z),
    .rate_x_i(rate_x), .rate_y_i(rate_y), .interval_us_i(interval_us),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pitch_angle_i(pitch_angle), .roll_angle_i(roll_angle),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // sink: hold stall for a drawn number of cycles after each result taken
  always @(negedge clk_i) took_out = out_valid && !out_stall;

  always @(posedge clk_i) begin
    if (took_out) stall_left = no_stalls ? 0 : $urandom_range(0, 8);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(negedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // called and returning at a rising edge
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] dt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    accel_x     <= ax;
    accel_y     <= ay;
    accel_z     <= az;
    rate_x      <= gx;
    rate_y      <= gy;
    interval_us <= dt;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // drain the filter until no request is outstanding
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ictf_pkg::CFG_IDX_W-1:0] idx,
                           logic [ictf_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4, 5: return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      2, 3, 4: return 16'($urandom_range(500, 1500));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        no_gaps   = ($urandom_range(0, 3) == 0);
        no_stalls = ($urandom_range(0, 3) == 0);
      end
      send_sample(pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                  pick_dt());
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vector, far negative axes, both extremes, zero interval
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'd1000);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_sample(16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0000);
    send_sample(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'd1);
    send_sample(16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'd1000);
    send_sample(16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'd1000);
    send_sample(16'h0000, 16'h8000, 16'h0000, 16'hff00, 16'h0100, 16'd1000);
    send_sample(16'h0000, 16'h0000, 16'h4000, 16'd131, -16'sd131, 16'd1000);
    send_sample(16'hc000, 16'h1000, 16'h1000, 16'h0001, 16'hffff, 16'd500);

    // full gyro weight and unit scale drive the estimate into saturation
    write_reg(ictf_pkg::CFG_BLEND_ALPHA, ictf_pkg::ALPHA_ONE);
    write_reg(ictf_pkg::CFG_GYRO_LSB, 17'd1);
    for (int i = 0; i < 6; i++)
      send_sample(16'h0000, 16'h0000, 16'h4000, 16'h7fff, 16'h8000, 16'hffff);
    random_run(150);

    // alpha above one acts as one; zero scale acts as one
    write_reg(ictf_pkg::CFG_BLEND_ALPHA, 17'h1ffff);
    write_reg(ictf_pkg::CFG_GYRO_LSB, 17'd0);
    random_run(150);

    // accelerometer only, slowest gyro
    write_reg(ictf_pkg::CFG_BLEND_ALPHA, 17'd0);
    write_reg(ictf_pkg::CFG_GYRO_LSB, 17'hffff);
    random_run(150);

    // unknown index is ignored
    write_reg(8'd2, 17'($urandom));
    write_reg(8'hff, 17'($urandom));
    write_reg(ictf_pkg::CFG_BLEND_ALPHA, ictf_pkg::ALPHA_RESET);
    write_reg(ictf_pkg::CFG_GYRO_LSB, 17'(ictf_pkg::LSB_RESET));
    random_run(200);

    for (int p = 0; p < 6; p++) begin
      write_reg(ictf_pkg::CFG_BLEND_ALPHA, 17'($urandom_range(0, 65536)));
      write_reg(ictf_pkg::CFG_GYRO_LSB, 17'($urandom_range(1, 65535)));
      random_run(150);
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
